/* design/imm_pkg.sv */
// Shared types and constants for the integer matrix multiply unit.
`default_nettype none

package imm_pkg;

    // Field widths fixed by the interface.
    localparam int ELEM_W = 16;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 35;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 4;

    // APB register port geometry.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Command codes on the func field.
    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_RUN    = 2'd2;

    // Register indexes (word address bits of paddr).
    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    // Sequencer states.
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // Control that travels with each multiply-accumulate step.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_l;
        logic             zero;
        logic             last_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } step_ctrl_t;

endpackage

`default_nettype wire

/* design/imm_store.sv */
// Matrix element store: one write port, one read port with registered data.
`default_nettype none

module imm_store
    import imm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [ELEM_W-1:0] wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic      [ELEM_W-1:0] rdata
);

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rdata_reg;

    // Write and registered read; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/imm_seq.sv */
// Run sequencer: walks i, j and l and issues one A and one B read per cycle.
`default_nettype none

module imm_seq
    import imm_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6,
    parameter int IW      = 3,
    parameter int DW      = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             run,
    input  wire logic [CFG_W-1:0] rows_a,
    input  wire logic [CFG_W-1:0] inner_dim,
    input  wire logic [CFG_W-1:0] cols_b,
    output logic      [AW-1:0]    a_addr,
    output logic      [AW-1:0]    b_addr,
    output step_ctrl_t            ctrl,
    output logic                  active
);

    seq_state_t state_reg, state_next;

    logic [IW-1:0] i_reg, j_reg, l_reg;
    logic [IW-1:0] n_last_reg, m_last_reg, k_last_reg;
    logic          zero_reg;

    logic [DW-1:0] n_clamp, m_clamp, k_clamp;
    logic          start_ok;
    logic          l_end, j_end, i_end;

    // Saturate a dimension register to MAX_DIM.
    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [DW-1:0] r;
        if (int'(d) > MAX_DIM)
        begin
            r = DW'(MAX_DIM);
        end
        else
        begin
            r = DW'(d);
        end
        return r;
    endfunction

    assign n_clamp  = clamp_dim(rows_a);
    assign m_clamp  = clamp_dim(inner_dim);
    assign k_clamp  = clamp_dim(cols_b);
    assign start_ok = run && (n_clamp != '0) && (k_clamp != '0);

    assign l_end = (l_reg == m_last_reg);
    assign j_end = (j_reg == k_last_reg);
    assign i_end = (i_reg == n_last_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start_ok)
                begin
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                if (l_end && j_end && i_end)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Loop counters; an empty inner dimension still takes one masked step.
    always_ff @(posedge clk)
    begin
        if (state_reg == SEQ_IDLE)
        begin
            if (start_ok)
            begin
                i_reg      <= '0;
                j_reg      <= '0;
                l_reg      <= '0;
                n_last_reg <= IW'(n_clamp - DW'(1));
                k_last_reg <= IW'(k_clamp - DW'(1));
                m_last_reg <= (m_clamp == '0) ? '0 : IW'(m_clamp - DW'(1));
                zero_reg   <= (m_clamp == '0);
            end
        end
        else
        begin
            if (l_end)
            begin
                l_reg <= '0;
                if (j_end)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + IW'(1);
                end
                else
                begin
                    j_reg <= j_reg + IW'(1);
                end
            end
            else
            begin
                l_reg <= l_reg + IW'(1);
            end
        end
    end

    // Step outputs: addresses and control for the current step.
    always_comb
    begin
        active         = (state_reg == SEQ_RUN);
        ctrl.valid     = (state_reg == SEQ_RUN);
        ctrl.first     = (l_reg == '0);
        ctrl.last_l    = l_end;
        ctrl.zero      = zero_reg;
        ctrl.last_elem = j_end && i_end;
        ctrl.row       = IDX_W'(i_reg);
        ctrl.col       = IDX_W'(j_reg);
        a_addr         = AW'(int'(i_reg) * MAX_DIM + int'(l_reg));
        b_addr         = AW'(int'(l_reg) * MAX_DIM + int'(j_reg));
    end

endmodule

`default_nettype wire

/* design/imm_mac.sv */
// Multiply-accumulate pipeline: registered product, then running sum and result.
`default_nettype none

module imm_mac
    import imm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire step_ctrl_t        ctrl,
    input  wire logic [ELEM_W-1:0] a_data,
    input  wire logic [ELEM_W-1:0] b_data,
    output logic                   result_valid,
    output logic      [IDX_W-1:0]  out_row,
    output logic      [IDX_W-1:0]  out_col,
    output logic      [PROD_W-1:0] product,
    output logic                   last,
    output logic                   pipe_busy
);

    step_ctrl_t s1_reg, s2_reg;

    logic [MUL_W-1:0]  prod_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] acc_next;
    logic              valid_reg;
    logic [IDX_W-1:0]  row_reg, col_reg;
    logic [PROD_W-1:0] product_reg;
    logic              last_reg;

    // Control follows the memory read, then the multiply.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= '0;
            s2_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg    <= ctrl;
            s2_reg    <= s1_reg;
            valid_reg <= s2_reg.valid && s2_reg.last_l;
        end
    end

    // Product of the two elements read last cycle.
    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_W'(a_data) * MUL_W'(b_data);
    end

    // Running sum restarts on the first step of each product element.
    always_comb
    begin
        acc_next = (s2_reg.first ? '0 : acc_reg)
                   + (s2_reg.zero ? '0 : PROD_W'(prod_reg));
    end

    always_ff @(posedge clk)
    begin
        if (s2_reg.valid)
        begin
            acc_reg <= acc_next;
            if (s2_reg.last_l)
            begin
                product_reg <= acc_next;
                row_reg     <= s2_reg.row;
                col_reg     <= s2_reg.col;
                last_reg    <= s2_reg.last_elem;
            end
        end
    end

    assign result_valid = valid_reg;
    assign out_row      = row_reg;
    assign out_col      = col_reg;
    assign product      = product_reg;
    assign last         = last_reg;
    assign pipe_busy    = s1_reg.valid || s2_reg.valid;

endmodule

`default_nettype wire

/* design/integer_matrix_multiply_unit.sv */
// Top level of the integer matrix multiply unit: registers, stores and pipeline.
//
//   Channel   Handshake                        Beat contents
//   command   start & !busy                    func, row, col, value
//   result    result_valid (one cycle, no stall) out_row, out_col, product, last
//   config    psel & penable & pwrite & pready rows_a, inner_dim, cols_b
//
// A load of A or B leaves busy low.
// A run sequences rows_a*cols_b*max(inner_dim,1) steps, each dimension
// saturated at MAX_DIM, one step per cycle, set by the single read port of each store;
// each step then passes the memory read, multiply and accumulate registers before its beat.
// Reset sets each dimension register to 1; store contents stay undefined until written.
// The result channel has no back pressure; busy stays high until the last beat shows.
`default_nettype none

module integer_matrix_multiply_unit
    import imm_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        func,
    input  wire logic [IDX_W-1:0]  row,
    input  wire logic [IDX_W-1:0]  col,
    input  wire logic [ELEM_W-1:0] value,
    output logic                   result_valid,
    output logic      [IDX_W-1:0]  out_row,
    output logic      [IDX_W-1:0]  out_col,
    output logic      [PROD_W-1:0] product,
    output logic                   last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);

    logic [CFG_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic             cfg_write;
    logic             accept;
    logic             in_range;
    logic             a_we, b_we, run;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    a_addr, b_addr;
    logic [ELEM_W-1:0] a_data, b_data;
    step_ctrl_t       seq_ctrl;
    logic             seq_active;
    logic             pipe_busy;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_W'(1);
            inner_dim_reg <= CFG_W'(1);
            cols_b_reg    <= CFG_W'(1);
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_ROWS_A:    rows_a_reg    <= pwdata[CFG_W-1:0];
                REG_INNER_DIM: inner_dim_reg <= pwdata[CFG_W-1:0];
                REG_COLS_B:    cols_b_reg    <= pwdata[CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Register read data.
    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS_A:    prdata = APB_DW'(rows_a_reg);
            REG_INNER_DIM: prdata = APB_DW'(inner_dim_reg);
            REG_COLS_B:    prdata = APB_DW'(cols_b_reg);
            default:       prdata = '0;
        endcase
    end

    // Command decode; loads outside the matrix bounds are dropped.
    assign accept   = start && !busy;
    assign in_range = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
    assign a_we     = accept && (func == FUNC_LOAD_A) && in_range;
    assign b_we     = accept && (func == FUNC_LOAD_B) && in_range;
    assign run      = accept && (func == FUNC_RUN);
    assign waddr    = AW'(int'(row) * MAX_DIM + int'(col));

    imm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (value),
        .raddr (a_addr),
        .rdata (a_data)
    );

    imm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (value),
        .raddr (b_addr),
        .rdata (b_data)
    );

    imm_seq #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW),
        .IW      (IW),
        .DW      (DW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (run),
        .rows_a    (rows_a_reg),
        .inner_dim (inner_dim_reg),
        .cols_b    (cols_b_reg),
        .a_addr    (a_addr),
        .b_addr    (b_addr),
        .ctrl      (seq_ctrl),
        .active    (seq_active)
    );

    imm_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (seq_ctrl),
        .a_data       (a_data),
        .b_data       (b_data),
        .result_valid (result_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .product      (product),
        .last         (last),
        .pipe_busy    (pipe_busy)
    );

    // Busy covers the sequencer and the steps still in the pipeline.
    assign busy = seq_active || pipe_busy;

    // A run with nonzero rows_a and cols_b must raise busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (run && (rows_a_reg != '0) && (cols_b_reg != '0)) |=> busy)
        else $error("run accepted but sequencer did not start");

    // Stores are never written while a run is reading them.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_we || b_we) |-> !seq_ctrl.valid)
        else $error("store write during an active run");

    // The final beat of a run is never followed directly by another beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("result beat after the final beat of a run");

    // Busy is low on the final beat, so the run is fully drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("pipeline still busy on the final result beat");

endmodule

`default_nettype wire

/* tb/integer_matrix_multiply_unit_test.sv */
// Self-checking testbench for the integer matrix multiply unit: loads, runs and dimension settings.
module integer_matrix_multiply_unit_test;
    import imm_pkg::*;

    localparam int MAX_DIM = 8;
    localparam int ITEM_TARGET = 230;
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT_UNITS = 4000000;
    localparam int DIRECTED_COUNT = 21;

    // Codes that the package leaves unnamed: the unused command and the unused register.
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [1:0] REG_SPARE  = 2'd3;

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_MIXED} fill_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] value;
    } command_t;

    typedef struct packed {
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [PROD_W-1:0] product;
        logic              last;
    } product_beat_t;

    typedef struct packed {
        command_t          cmd;
        logic              typed;
        logic [PROD_W-1:0] want_product;
    } directed_row_t;

    // Directed commands at the reset dimensions 1x1x1; typed rows expect a single beat at (0,0).
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{FUNC_LOAD_A, 3'd0, 3'd0, 16'hFFFF}, 1'b0, 35'd0},
        '{'{FUNC_LOAD_B, 3'd0, 3'd0, 16'hFFFF}, 1'b0, 35'd0},
        '{'{FUNC_RUN,    3'd0, 3'd0, 16'h0000}, 1'b1, 35'hFFFE0001},
        '{'{FUNC_LOAD_A, 3'd0, 3'd0, 16'h0000}, 1'b0, 35'd0},
        '{'{FUNC_RUN,    3'd0, 3'd0, 16'h0000}, 1'b1, 35'd0},
        '{'{FUNC_SPARE,  3'd7, 3'd7, 16'hFFFF}, 1'b0, 35'd0},
        '{'{FUNC_RUN,    3'd7, 3'd7, 16'hFFFF}, 1'b1, 35'd0},
        '{'{FUNC_LOAD_A, 3'd7, 3'd7, 16'hFFFF}, 1'b0, 35'd0},
        '{'{FUNC_LOAD_B, 3'd7, 3'd7, 16'hFFFF}, 1'b0, 35'd0},
        '{'{FUNC_RUN,    3'd0, 3'd0, 16'h0000}, 1'b1, 35'd0},
        '{'{FUNC_LOAD_A, 3'd0, 3'd0, 16'h0001}, 1'b0, 35'd0},
        '{'{FUNC_LOAD_B, 3'd0, 3'd0, 16'h5555}, 1'b0, 35'd0},
        '{'{FUNC_RUN,    3'd0, 3'd0, 16'h0000}, 1'b1, 35'h5555},
        '{'{FUNC_LOAD_B, 3'd0, 3'd0, 16'h8000}, 1'b0, 35'd0},
        '{'{FUNC_LOAD_A, 3'd0, 3'd0, 16'h0002}, 1'b0, 35'd0},
        '{'{FUNC_RUN,    3'd0, 3'd0, 16'h0000}, 1'b1, 35'h10000},
        '{'{FUNC_RUN,    3'd0, 3'd0, 16'h0000}, 1'b1, 35'h10000},
        '{'{FUNC_LOAD_A, 3'd5, 3'd2, 16'h1234}, 1'b0, 35'd0},
        '{'{FUNC_LOAD_B, 3'd2, 3'd5, 16'hABCD}, 1'b0, 35'd0},
        '{'{FUNC_LOAD_A, 3'd0, 3'd0, 16'hAAAA}, 1'b0, 35'd0},
        '{'{FUNC_RUN,    3'd0, 3'd0, 16'h0000}, 1'b0, 35'd0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [1:0]        func = FUNC_LOAD_A;
    logic [IDX_W-1:0]  row = '0;
    logic [IDX_W-1:0]  col = '0;
    logic [ELEM_W-1:0] value = '0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic              busy;
    logic              result_valid;
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic [PROD_W-1:0] product;
    logic              last;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Shadow copy of the block: both element stores and the three dimension registers.
    logic [ELEM_W-1:0] a_store [MAX_DIM*MAX_DIM];
    logic [ELEM_W-1:0] b_store [MAX_DIM*MAX_DIM];
    bit                a_written [MAX_DIM*MAX_DIM];
    bit                b_written [MAX_DIM*MAX_DIM];
    logic [CFG_W-1:0]  dim_rows = 4'd1;
    logic [CFG_W-1:0]  dim_inner = 4'd1;
    logic [CFG_W-1:0]  dim_cols = 4'd1;

    product_beat_t pending_products [$];
    int unsigned   fail_count = 0;
    int unsigned   commands_sent = 0;
    int unsigned   runs_sent = 0;
    int unsigned   beats_seen = 0;
    int unsigned   phase_count = 0;

    integer_matrix_multiply_unit #(.MAX_DIM(MAX_DIM)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .row(row),
        .col(col),
        .value(value),
        .result_valid(result_valid),
        .out_row(out_row),
        .out_col(out_col),
        .product(product),
        .last(last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    initial
    begin
        #TIMEOUT_UNITS;
        $display("Timeout with %0d product beats still pending.", pending_products.size());
        $display("integer_matrix_multiply_unit_test NOT OK");
        $finish;
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : d;
    endfunction

    function automatic command_t make_command(input logic [1:0] f, input int unsigned r,
                                              input int unsigned c, input logic [ELEM_W-1:0] v);
        command_t cmd;
        cmd.func = f;
        cmd.row = IDX_W'(r);
        cmd.col = IDX_W'(c);
        cmd.value = v;
        return cmd;
    endfunction

    // Sender gaps: moderate idling first, then heavy idling, then back to back.
    function automatic int unsigned sender_idle_percent();
        if (commands_sent < ITEM_TARGET / 3)
            return 36;
        else if (commands_sent < 2 * ITEM_TARGET / 3)
            return 73;
        return 0;
    endfunction

    function automatic logic [ELEM_W-1:0] pick_value(input fill_t fill);
        case (fill)
            FILL_ONES: return '1;
            FILL_MIXED:
                case ($urandom_range(2))
                    0: return '0;
                    1: return '1;
                    default: return ELEM_W'($urandom());
                endcase
            default: return ELEM_W'($urandom());
        endcase
    endfunction

    function automatic void apply_register(input logic [1:0] index, input logic [APB_DW-1:0] data);
        case (index)
            REG_ROWS_A: dim_rows = data[CFG_W-1:0];
            REG_INNER_DIM: dim_inner = data[CFG_W-1:0];
            REG_COLS_B: dim_cols = data[CFG_W-1:0];
            default: ;
        endcase
    endfunction

    // Updates the shadow stores on a load; on a run, queues every product element in row-major order.
    function automatic void predict_command(input command_t cmd);
        int unsigned       n, m, k, total, count;
        logic [PROD_W-1:0] acc;
        product_beat_t     beat;
        case (cmd.func)
            FUNC_LOAD_A:
            begin
                a_store[{cmd.row, cmd.col}] = cmd.value;
                a_written[{cmd.row, cmd.col}] = 1'b1;
            end
            FUNC_LOAD_B:
            begin
                b_store[{cmd.row, cmd.col}] = cmd.value;
                b_written[{cmd.row, cmd.col}] = 1'b1;
            end
            FUNC_RUN:
            begin
                n = clamp_dim(dim_rows);
                m = clamp_dim(dim_inner);
                k = clamp_dim(dim_cols);
                total = n * k;
                count = 0;
                for (int i = 0; i < n; i++)
                begin
                    for (int j = 0; j < k; j++)
                    begin
                        acc = '0;
                        for (int l = 0; l < m; l++)
                            acc = acc + PROD_W'(a_store[{IDX_W'(i), IDX_W'(l)}])
                                      * PROD_W'(b_store[{IDX_W'(l), IDX_W'(j)}]);
                        beat.row = IDX_W'(i);
                        beat.col = IDX_W'(j);
                        beat.product = acc;
                        beat.last = (count + 1 == total);
                        pending_products.push_back(beat);
                        count++;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Presents one command and holds it until the block takes it.
    task automatic send_command(input command_t cmd);
        while ($urandom_range(99) < sender_idle_percent())
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        func <= cmd.func;
        row <= cmd.row;
        col <= cmd.col;
        value <= cmd.value;
        do
            @(posedge clk);
        while (busy);
        if (cmd.func != FUNC_SPARE)
            commands_sent++;
        if (cmd.func == FUNC_RUN)
            runs_sent++;
    endtask

    task automatic issue(input command_t cmd);
        send_command(cmd);
        predict_command(cmd);
    endtask

    // An ignored command or a load to any position of either store.
    task automatic issue_noise();
        if ($urandom_range(1))
            issue(make_command(FUNC_SPARE, $urandom_range(7), $urandom_range(7),
                               ELEM_W'($urandom())));
        else
            issue(make_command($urandom_range(1) ? FUNC_LOAD_B : FUNC_LOAD_A,
                               $urandom_range(7), $urandom_range(7), ELEM_W'($urandom())));
    endtask

    // Drops start and waits until every product beat is in and the block is idle.
    task automatic settle();
        start <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Register write: setup cycle, access cycle, then the bus is left idle.
    task automatic write_register(input logic [1:0] index, input logic [CFG_W-1:0] dim);
        logic [APB_DW-1:0] data;
        data = $urandom();
        data[CFG_W-1:0] = dim;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        apply_register(index, data);
        @(posedge clk);
    endtask

    // One dimension setting: program it, load the operands in shuffled order, run, maybe patch and rerun.
    task automatic run_phase(input logic [CFG_W-1:0] rows_cfg, input logic [CFG_W-1:0] inner_cfg,
                             input logic [CFG_W-1:0] cols_cfg, input fill_t fill);
        command_t    plan [$];
        command_t    held;
        int unsigned n, m, k, pick;
        settle();
        write_register(REG_ROWS_A, rows_cfg);
        write_register(REG_INNER_DIM, inner_cfg);
        write_register(REG_COLS_B, cols_cfg);
        if (phase_count == 0 || $urandom_range(3) == 0)
            write_register(REG_SPARE, CFG_W'($urandom_range(15)));
        phase_count++;
        n = clamp_dim(rows_cfg);
        m = clamp_dim(inner_cfg);
        k = clamp_dim(cols_cfg);

        // Only entries that the run reads are planned; unwritten ones are always loaded.
        if (n * k != 0)
        begin
            for (int i = 0; i < n; i++)
                for (int l = 0; l < m; l++)
                    if (fill != FILL_RANDOM || !a_written[{IDX_W'(i), IDX_W'(l)}]
                        || $urandom_range(99) < 75)
                        plan.push_back(make_command(FUNC_LOAD_A, i, l, pick_value(fill)));
            for (int l = 0; l < m; l++)
                for (int j = 0; j < k; j++)
                    if (fill != FILL_RANDOM || !b_written[{IDX_W'(l), IDX_W'(j)}]
                        || $urandom_range(99) < 75)
                        plan.push_back(make_command(FUNC_LOAD_B, l, j, pick_value(fill)));
        end
        for (int s = plan.size() - 1; s > 0; s--)
        begin
            pick = $urandom_range(s);
            held = plan[s];
            plan[s] = plan[pick];
            plan[pick] = held;
        end

        foreach (plan[p])
        begin
            if ($urandom_range(99) < 8)
                issue_noise();
            issue(plan[p]);
        end
        issue(make_command(FUNC_RUN, $urandom_range(7), $urandom_range(7), ELEM_W'($urandom())));

        // Change a few operands and run again without settle(); busy still holds each command off.
        if ($urandom_range(99) < 40)
        begin
            if (n * k * m != 0)
                repeat ($urandom_range(1, 3))
                    if ($urandom_range(1))
                        issue(make_command(FUNC_LOAD_A, $urandom_range(n - 1),
                                           $urandom_range(m - 1), pick_value(fill)));
                    else
                        issue(make_command(FUNC_LOAD_B, $urandom_range(m - 1),
                                           $urandom_range(k - 1), pick_value(fill)));
            issue(make_command(FUNC_RUN, $urandom_range(7), $urandom_range(7),
                               ELEM_W'($urandom())));
        end
    endtask

    function automatic logic [CFG_W-1:0] random_dim();
        if ($urandom_range(99) < 85)
            return CFG_W'($urandom_range(1, 4));
        return CFG_W'($urandom_range(15));
    endfunction

    // Every product beat is matched against the oldest pending expectation.
    always @(posedge clk)
    begin
        product_beat_t want;
        if (rst_n && result_valid)
        begin
            beats_seen++;
            if (pending_products.size() == 0)
            begin
                $display("%0t: unexpected product beat: row %0d col %0d product %0h last %0b",
                         $time, out_row, out_col, product, last);
                fail_count++;
            end
            else
            begin
                want = pending_products.pop_front();
                check_field("out_row", 64'(want.row), 64'(out_row));
                check_field("out_col", 64'(want.col), 64'(out_col));
                check_field("product", 64'(want.product), 64'(product));
                check_field("last", 64'(want.last), 64'(last));
            end
        end
    end

    // Main sequence: reset, directed table, corner settings, then random settings.
    initial
    begin
        command_t cmd;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int d = 0; d < DIRECTED_COUNT; d++)
        begin
            cmd = DIRECTED_ROWS[d].cmd;
            send_command(cmd);
            if (DIRECTED_ROWS[d].typed)
                pending_products.push_back('{'0, '0, DIRECTED_ROWS[d].want_product, 1'b1});
            else
                predict_command(cmd);
        end

        // Largest possible sum, saturated dimensions, empty products and an empty inner dimension.
        run_phase(4'd1, 4'd15, 4'd1, FILL_ONES);
        run_phase(4'd15, 4'd1, 4'd15, FILL_MIXED);
        run_phase(4'd0, 4'd3, 4'd2, FILL_RANDOM);
        run_phase(4'd2, 4'd3, 4'd0, FILL_RANDOM);
        run_phase(4'd2, 4'd0, 4'd3, FILL_RANDOM);
        run_phase(4'd8, 4'd2, 4'd8, FILL_MIXED);
        while (commands_sent < ITEM_TARGET)
            run_phase(random_dim(), random_dim(), random_dim(), fill_t'($urandom_range(2)));

        settle();
        $display("Sent %0d commands including %0d runs over %0d dimension settings.",
                 commands_sent, runs_sent, phase_count);
        $display("Checked %0d product beats.", beats_seen);
        if (fail_count == 0)
            $display("integer_matrix_multiply_unit_test OK");
        else
            $display("integer_matrix_multiply_unit_test NOT OK");
        $finish;
    end

endmodule
